// File: hdl/lbcd_pkg.sv
// Shared types, constants and codes of the LRU block cache directory.
package lbcd_pkg;

	localparam int ADDR_BITS       = 40;
	localparam int TAG_W           = 28;
	localparam int SIZE_W          = 25;
	localparam int TOT_W           = 32;
	localparam int LG_W            = 5;
	localparam int CAP_W           = 7;
	localparam int MAX_ENTRIES_DEF = 64;
	localparam int MAX_SPAN_DEF    = 16;
	localparam logic [LG_W-1:0]  LG_MIN    = LG_W'(12);
	localparam logic [LG_W-1:0]  LG_MAX    = LG_W'(24);
	localparam logic [LG_W-1:0]  LG_RESET  = LG_W'(20);
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_FILL   = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		K_HIT     = 3'd0,
		K_MISS    = 3'd1,
		K_FILLED  = 3'd2,
		K_CLEARED = 3'd3,
		K_SPAN    = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		CFG_LG   = 2'd0,
		CFG_CAP  = 2'd1,
		CFG_FILE = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		op_t                  operation;
		logic [ADDR_BITS-1:0] offset;
		logic [SIZE_W-1:0]    size;
		logic [TAG_W-1:0]     block_index;
	} req_t;

	typedef struct packed {
		kind_t                kind;
		logic [TAG_W-1:0]     blk_num;
		logic [ADDR_BITS-1:0] byte_start;
		logic [SIZE_W-1:0]    byte_count;
		logic [TOT_W-1:0]     hit_count;
		logic [TOT_W-1:0]     miss_count;
		logic                 last;
	} res_t;

	// lg is already clamped to its legal range
	typedef struct packed {
		logic [LG_W-1:0]      lg;
		logic [CAP_W-1:0]     cap;
		logic [ADDR_BITS-1:0] file_len;
	} cfg_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_L_CHK1,
		ST_L_CHK2,
		ST_L_SCAN,
		ST_L_DECIDE,
		ST_H_SEL,
		ST_T_READ,
		ST_T_WAIT,
		ST_T_SWEEP,
		ST_H_P1,
		ST_H_P2,
		ST_H_EMIT,
		ST_M_NEXT,
		ST_M_EMIT,
		ST_F_SCAN,
		ST_F_DECIDE,
		ST_F_CHK,
		ST_F_EVICT,
		ST_F_DROP,
		ST_F_INSERT,
		ST_F_PLACE,
		ST_F_DONE
	} st_t;

endpackage

// File: hdl/lbcd_mem.sv
// Tag and recency rank memory: one write port, one registered read port.
module lbcd_mem #(
	parameter int DEPTH = lbcd_pkg::MAX_ENTRIES_DEF,
	parameter int AW    = $clog2(DEPTH),
	parameter int DW    = lbcd_pkg::TAG_W + AW
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: hdl/lbcd_ctrl.sv
// Sequencer: sweeps the tag/rank memory for lookups, fills, evictions and touches.
module lbcd_ctrl #(
	parameter int MAX_ENTRIES = lbcd_pkg::MAX_ENTRIES_DEF,
	parameter int MAX_SPAN    = lbcd_pkg::MAX_SPAN_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  lbcd_pkg::req_t  cmd,
	input  lbcd_pkg::cfg_t  cfg,
	output logic            result_valid,
	output lbcd_pkg::res_t  result
);

	localparam int AW  = $clog2(MAX_ENTRIES);
	localparam int DW  = lbcd_pkg::TAG_W + AW;
	localparam int CW  = AW + 1;
	localparam int SPW = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;
	localparam int SNW = $clog2(MAX_SPAN + 1);
	localparam int AB  = lbcd_pkg::ADDR_BITS;
	localparam int TW  = lbcd_pkg::TAG_W;
	localparam int XW  = AB + 1;

	lbcd_pkg::st_t state_q, state_d;
	lbcd_pkg::req_t cmd_q;
	lbcd_pkg::res_t out_q;
	logic                      out_valid_q;

	logic [CW-1:0]             cnt_q;
	logic [MAX_ENTRIES-1:0]    valid_q;
	logic [CW-1:0]             occ_q;
	logic [lbcd_pkg::TOT_W-1:0] hit_q, miss_q;
	logic [XW-1:0]             rend_q;
	logic [TW-1:0]             sb_q;
	logic [SNW-1:0]            span_q, k_q;
	logic [MAX_SPAN-1:0]       present_q;
	logic [AW-1:0]             idx_q [MAX_SPAN];
	logic [AW-1:0]             e_q, pick_q, slot_q;
	logic [AW-1:0]             r_q, pick_rank_q;
	logic                      found_q, pick_ok_q, slot_ok_q, is_fill_q;
	logic [XW-1:0]             bstart_q, bend_q, ps_q, pe_q;

	// memory port
	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [DW-1:0] mem_wdata, mem_rdata;
	logic [TW-1:0] rd_tag;
	logic [AW-1:0] rd_rank;
	logic [AW-1:0] paddr;
	logic          pvalid, sweep_end, sweeping;

	lbcd_mem #(.DEPTH(MAX_ENTRIES), .AW(AW), .DW(DW)) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign rd_tag    = mem_rdata[DW-1:AW];
	assign rd_rank   = mem_rdata[AW-1:0];
	assign paddr     = AW'(cnt_q - CW'(1));
	assign pvalid    = (cnt_q != '0) && valid_q[paddr];
	assign sweep_end = (cnt_q == CW'(MAX_ENTRIES));
	assign sweeping  = (state_q == lbcd_pkg::ST_L_SCAN) || (state_q == lbcd_pkg::ST_F_SCAN) ||
		(state_q == lbcd_pkg::ST_T_SWEEP) || (state_q == lbcd_pkg::ST_F_EVICT) ||
		(state_q == lbcd_pkg::ST_F_INSERT);

	assign busy         = (state_q != lbcd_pkg::ST_IDLE);
	assign result_valid = out_valid_q;
	assign result       = out_q;

	// range arithmetic
	logic [XW-1:0]   endv, bsz, blk_x;
	logic [AB-1:0]   sbv, ebv, spanv;
	logic [TW-1:0]   blk, diff;
	logic [MAX_SPAN-1:0] absent;
	logic            more_absent;
	logic [SNW-1:0]  nmiss;
	logic [lbcd_pkg::TOT_W:0] miss_sum;
	logic [15:0]     cap_eff, occ16;
	logic [XW-1:0]   ps_v, pe_v, cnt_v, len_v;

	always_comb begin
		endv  = rend_q - XW'(1);
		sbv   = cmd_q.offset >> cfg.lg;
		ebv   = endv[AB-1:0] >> cfg.lg;
		spanv = ebv - sbv + AB'(1);
		bsz   = XW'(1) << cfg.lg;
		blk   = sb_q + TW'(k_q);
		blk_x = XW'(blk);
		diff  = rd_tag - sb_q;
		nmiss = '0;
		more_absent = 1'b0;
		for (int j = 0; j < MAX_SPAN; j++) begin
			absent[j] = !present_q[j] && (SNW'(j) < span_q);
			nmiss = nmiss + SNW'(absent[j]);
			if ((SNW'(j) > k_q) && absent[j]) more_absent = 1'b1;
		end
		miss_sum = {1'b0, miss_q} + (lbcd_pkg::TOT_W + 1)'(nmiss);
		if (cfg.cap == '0) cap_eff = 16'd1;
		else if (16'(cfg.cap) > 16'(MAX_ENTRIES)) cap_eff = 16'(MAX_ENTRIES);
		else cap_eff = 16'(cfg.cap);
		occ16 = 16'(occ_q);
		ps_v  = (XW'(cmd_q.offset) > bstart_q) ? XW'(cmd_q.offset) : bstart_q;
		pe_v  = (rend_q < bend_q) ? rend_q : bend_q;
		if (XW'(cfg.file_len) < pe_v) pe_v = XW'(cfg.file_len);
		cnt_v = (pe_q > ps_q) ? pe_q - ps_q : '0;
		len_v = XW'(cfg.file_len) - bstart_q;
		if (bstart_q >= XW'(cfg.file_len)) len_v = '0;
		else if (len_v > bsz) len_v = bsz;
	end

	// next state and memory port
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = paddr;
		mem_wdata = {rd_tag, rd_rank + AW'(1)};
		mem_raddr = cnt_q[AW-1:0];
		unique case (state_q)
			lbcd_pkg::ST_IDLE: begin
				if (start) begin
					if (cmd.operation == lbcd_pkg::OP_LOOKUP) state_d = lbcd_pkg::ST_L_CHK1;
					else if (cmd.operation == lbcd_pkg::OP_FILL) state_d = lbcd_pkg::ST_F_SCAN;
				end
			end
			lbcd_pkg::ST_L_CHK1: begin
				state_d = (cmd_q.size == '0) ? lbcd_pkg::ST_IDLE : lbcd_pkg::ST_L_CHK2;
			end
			lbcd_pkg::ST_L_CHK2: begin
				if (endv[AB] || (ebv[AB-1:TW] != '0) || (spanv > AB'(MAX_SPAN)))
					state_d = lbcd_pkg::ST_IDLE;
				else
					state_d = lbcd_pkg::ST_L_SCAN;
			end
			lbcd_pkg::ST_L_SCAN: begin
				if (sweep_end) state_d = lbcd_pkg::ST_L_DECIDE;
			end
			lbcd_pkg::ST_L_DECIDE: begin
				state_d = (absent == '0) ? lbcd_pkg::ST_H_SEL : lbcd_pkg::ST_M_NEXT;
			end
			lbcd_pkg::ST_H_SEL: state_d = lbcd_pkg::ST_T_READ;
			lbcd_pkg::ST_T_READ: begin
				mem_raddr = e_q;
				state_d   = lbcd_pkg::ST_T_WAIT;
			end
			lbcd_pkg::ST_T_WAIT: state_d = lbcd_pkg::ST_T_SWEEP;
			lbcd_pkg::ST_T_SWEEP: begin
				// move the touched entry to the front, age the younger ones
				if (pvalid) begin
					if (paddr == e_q) begin
						mem_we    = 1'b1;
						mem_wdata = {rd_tag, AW'(0)};
					end else if (rd_rank < r_q) begin
						mem_we = 1'b1;
					end
				end
				if (sweep_end) state_d = is_fill_q ? lbcd_pkg::ST_F_DONE : lbcd_pkg::ST_H_P1;
			end
			lbcd_pkg::ST_H_P1: state_d = lbcd_pkg::ST_H_P2;
			lbcd_pkg::ST_H_P2: state_d = lbcd_pkg::ST_H_EMIT;
			lbcd_pkg::ST_H_EMIT: begin
				state_d = (k_q == span_q - SNW'(1)) ? lbcd_pkg::ST_IDLE : lbcd_pkg::ST_H_SEL;
			end
			lbcd_pkg::ST_M_NEXT: begin
				if (absent[k_q[SPW-1:0]]) state_d = lbcd_pkg::ST_M_EMIT;
			end
			lbcd_pkg::ST_M_EMIT: begin
				state_d = more_absent ? lbcd_pkg::ST_M_NEXT : lbcd_pkg::ST_IDLE;
			end
			lbcd_pkg::ST_F_SCAN: begin
				if (sweep_end) state_d = lbcd_pkg::ST_F_DECIDE;
			end
			lbcd_pkg::ST_F_DECIDE: begin
				state_d = found_q ? lbcd_pkg::ST_T_READ : lbcd_pkg::ST_F_CHK;
			end
			lbcd_pkg::ST_F_CHK: begin
				state_d = (occ16 >= cap_eff) ? lbcd_pkg::ST_F_EVICT : lbcd_pkg::ST_F_INSERT;
			end
			lbcd_pkg::ST_F_EVICT: begin
				if (sweep_end) state_d = lbcd_pkg::ST_F_DROP;
			end
			lbcd_pkg::ST_F_DROP: state_d = lbcd_pkg::ST_F_CHK;
			lbcd_pkg::ST_F_INSERT: begin
				if (pvalid) mem_we = 1'b1;
				if (sweep_end) state_d = lbcd_pkg::ST_F_PLACE;
			end
			lbcd_pkg::ST_F_PLACE: begin
				mem_we    = 1'b1;
				mem_waddr = slot_q;
				mem_wdata = {cmd_q.block_index, AW'(0)};
				state_d   = lbcd_pkg::ST_F_DONE;
			end
			lbcd_pkg::ST_F_DONE: state_d = lbcd_pkg::ST_IDLE;
			default: state_d = lbcd_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lbcd_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			valid_q     <= '0;
			occ_q       <= '0;
			hit_q       <= '0;
			miss_q      <= '0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= 1'b0;
			cnt_q       <= (sweeping && state_d == state_q) ? cnt_q + CW'(1) : '0;
			case (state_q)
				lbcd_pkg::ST_IDLE: begin
					if (start && cmd.operation == lbcd_pkg::OP_CLEAR) begin
						valid_q     <= '0;
						occ_q       <= '0;
						hit_q       <= '0;
						miss_q      <= '0;
						out_valid_q <= 1'b1;
					end
				end
				lbcd_pkg::ST_L_CHK2: begin
					if (state_d == lbcd_pkg::ST_IDLE) out_valid_q <= 1'b1;
				end
				lbcd_pkg::ST_L_DECIDE: begin
					if (absent == '0) begin
						if (!(&hit_q)) hit_q <= hit_q + lbcd_pkg::TOT_W'(1);
					end else begin
						miss_q <= miss_sum[lbcd_pkg::TOT_W] ? '1 : miss_sum[lbcd_pkg::TOT_W-1:0];
					end
				end
				lbcd_pkg::ST_H_EMIT, lbcd_pkg::ST_M_EMIT, lbcd_pkg::ST_F_DONE: begin
					out_valid_q <= 1'b1;
				end
				lbcd_pkg::ST_F_DROP: begin
					valid_q[pick_q] <= 1'b0;
					occ_q           <= occ_q - CW'(1);
				end
				lbcd_pkg::ST_F_PLACE: begin
					valid_q[slot_q] <= 1'b1;
					occ_q           <= occ_q + CW'(1);
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			lbcd_pkg::ST_IDLE: begin
				cmd_q   <= cmd;
				found_q <= 1'b0;
				out_q   <= '{kind: lbcd_pkg::K_CLEARED, blk_num: '0, byte_start: '0,
					byte_count: '0, hit_count: '0, miss_count: '0, last: 1'b1};
			end
			lbcd_pkg::ST_L_CHK1: begin
				rend_q <= XW'(cmd_q.offset) + XW'(cmd_q.size);
			end
			lbcd_pkg::ST_L_CHK2: begin
				sb_q      <= TW'(sbv);
				span_q    <= SNW'(spanv);
				present_q <= '0;
				k_q       <= '0;
				out_q     <= '{kind: lbcd_pkg::K_SPAN, blk_num: '0, byte_start: '0,
					byte_count: '0, hit_count: hit_q, miss_count: miss_q, last: 1'b1};
			end
			lbcd_pkg::ST_L_SCAN: begin
				if (pvalid && rd_tag >= sb_q && diff < TW'(span_q)) begin
					present_q[diff[SPW-1:0]] <= 1'b1;
					idx_q[diff[SPW-1:0]]     <= paddr;
				end
			end
			lbcd_pkg::ST_H_SEL: begin
				e_q       <= idx_q[k_q[SPW-1:0]];
				is_fill_q <= 1'b0;
			end
			lbcd_pkg::ST_T_WAIT: r_q <= rd_rank;
			lbcd_pkg::ST_H_P1: begin
				bstart_q <= blk_x << cfg.lg;
				bend_q   <= (blk_x + XW'(1)) << cfg.lg;
			end
			lbcd_pkg::ST_H_P2: begin
				ps_q <= ps_v;
				pe_q <= pe_v;
			end
			lbcd_pkg::ST_H_EMIT: begin
				out_q <= '{kind: lbcd_pkg::K_HIT, blk_num: blk,
					byte_start: AB'(ps_q - bstart_q), byte_count: lbcd_pkg::SIZE_W'(cnt_v),
					hit_count: hit_q, miss_count: miss_q,
					last: (k_q == span_q - SNW'(1))};
				k_q <= k_q + SNW'(1);
			end
			lbcd_pkg::ST_M_NEXT: begin
				if (absent[k_q[SPW-1:0]]) bstart_q <= blk_x << cfg.lg;
				else k_q <= k_q + SNW'(1);
			end
			lbcd_pkg::ST_M_EMIT: begin
				out_q <= '{kind: lbcd_pkg::K_MISS, blk_num: blk,
					byte_start: AB'(bstart_q), byte_count: lbcd_pkg::SIZE_W'(len_v),
					hit_count: hit_q, miss_count: miss_q, last: !more_absent};
				k_q <= k_q + SNW'(1);
			end
			lbcd_pkg::ST_F_SCAN: begin
				if (pvalid && rd_tag == cmd_q.block_index) begin
					found_q <= 1'b1;
					e_q     <= paddr;
				end
				is_fill_q <= 1'b1;
			end
			lbcd_pkg::ST_F_CHK: begin
				pick_ok_q <= 1'b0;
				slot_ok_q <= 1'b0;
			end
			lbcd_pkg::ST_F_EVICT: begin
				if (pvalid && (!pick_ok_q || rd_rank > pick_rank_q)) begin
					pick_ok_q   <= 1'b1;
					pick_q      <= paddr;
					pick_rank_q <= rd_rank;
				end
			end
			lbcd_pkg::ST_F_INSERT: begin
				// take the first free entry
				if (cnt_q != '0 && !valid_q[paddr] && !slot_ok_q) begin
					slot_ok_q <= 1'b1;
					slot_q    <= paddr;
				end
			end
			lbcd_pkg::ST_F_DONE: begin
				out_q <= '{kind: lbcd_pkg::K_FILLED, blk_num: cmd_q.block_index,
					byte_start: '0, byte_count: '0, hit_count: hit_q, miss_count: miss_q,
					last: 1'b1};
			end
			default: ;
		endcase
	end

endmodule

// File: hdl/lru_block_cache_directory.sv
// Tag directory of a fully associative LRU block cache: an item is taken when start is high
// and busy is low; results leave on result with result_valid and cannot be held off. Every
// directory pass walks the tag/rank memory one entry a cycle through its single read port.
// A lookup first checks its range, then makes a pass to find its blocks; when all blocks hit,
// each block then gets a touch pass, else each missing block is reported in turn. A fill
// makes a pass to find its block and then a touch pass if it is held; for a new block it makes
// an eviction pass per entry to evict and then an insert pass. A span error is reported
// without a pass; a clear needs no pass and an empty lookup ends with no result.
module lru_block_cache_directory #(
	parameter int MAX_ENTRIES = lbcd_pkg::MAX_ENTRIES_DEF,
	parameter int MAX_SPAN    = lbcd_pkg::MAX_SPAN_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  lbcd_pkg::req_t                   cmd,
	output logic                             result_valid,
	output lbcd_pkg::res_t                   result,
	input  logic                             cfg_write,
	input  logic [1:0]                       cfg_index,
	input  logic [lbcd_pkg::ADDR_BITS-1:0]   cfg_data
);

	logic [lbcd_pkg::LG_W-1:0]      lg_q;
	logic [lbcd_pkg::CAP_W-1:0]     cap_q;
	logic [lbcd_pkg::ADDR_BITS-1:0] file_q;
	lbcd_pkg::cfg_t                 cfg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lg_q   <= lbcd_pkg::LG_RESET;
			cap_q  <= lbcd_pkg::CAP_RESET;
			file_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				lbcd_pkg::CFG_LG:   lg_q   <= cfg_data[lbcd_pkg::LG_W-1:0];
				lbcd_pkg::CFG_CAP:  cap_q  <= cfg_data[lbcd_pkg::CAP_W-1:0];
				lbcd_pkg::CFG_FILE: file_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp block size to the supported range
	always_comb begin
		if (lg_q < lbcd_pkg::LG_MIN) cfg.lg = lbcd_pkg::LG_MIN;
		else if (lg_q > lbcd_pkg::LG_MAX) cfg.lg = lbcd_pkg::LG_MAX;
		else cfg.lg = lg_q;
		cfg.cap      = cap_q;
		cfg.file_len = file_q;
	end

	lbcd_ctrl #(.MAX_ENTRIES(MAX_ENTRIES), .MAX_SPAN(MAX_SPAN)) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.cfg         (cfg),
		.result_valid(result_valid),
		.result      (result)
	);

endmodule

// File: tb/tb_lru_block_cache_directory.sv
// Self-checking testbench of the LRU block cache directory: directed and random items.
module tb_lru_block_cache_directory;

	localparam int N_ENT  = lbcd_pkg::MAX_ENTRIES_DEF;
	localparam int N_SPAN = lbcd_pkg::MAX_SPAN_DEF;
	localparam int AB     = lbcd_pkg::ADDR_BITS;
	localparam int TW     = lbcd_pkg::TAG_W;
	localparam int TOTW   = lbcd_pkg::TOT_W;
	localparam logic [AB-1:0] ADDR_TOP = {AB{1'b1}};

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	lbcd_pkg::req_t       cmd;
	logic                 result_valid;
	lbcd_pkg::res_t       result;
	logic                 cfg_write;
	logic [1:0]           cfg_index;
	logic [AB-1:0]        cfg_data;

	lru_block_cache_directory u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.result_valid(result_valid), .result(result),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state
	logic [TW-1:0]               dir_tag [N_ENT];
	logic                        dir_vld [N_ENT];
	int unsigned                 dir_rank[N_ENT];
	int unsigned                 dir_occ;
	logic [TOTW-1:0]             hits, misses;
	logic [lbcd_pkg::LG_W-1:0]   mdl_lg;
	logic [lbcd_pkg::CAP_W-1:0]  mdl_cap;
	logic [AB-1:0]               mdl_file;

	lbcd_pkg::req_t pending_items[$];
	lbcd_pkg::res_t expected_results[$];
	bit   fail;
	bit   quiet;
	int   gap;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#400000000;
		$display("lru_block_cache_directory regression: fail");
		$finish;
	end

	function automatic void reset_model();
		for (int i = 0; i < N_ENT; i++) begin
			dir_vld[i] = 0;
			dir_rank[i] = 0;
			dir_tag[i] = '0;
		end
		dir_occ = 0;
		hits = 0;
		misses = 0;
	endfunction

	function automatic int find_block(logic [TW-1:0] b);
		for (int i = 0; i < N_ENT; i++)
			if (dir_vld[i] && dir_tag[i] == b) return i;
		return -1;
	endfunction

	function automatic void make_recent(int e);
		int unsigned r;
		r = dir_rank[e];
		for (int i = 0; i < N_ENT; i++)
			if (dir_vld[i] && dir_rank[i] < r) dir_rank[i]++;
		dir_rank[e] = 0;
	endfunction

	function automatic logic [TOTW-1:0] sat_up(logic [TOTW-1:0] v);
		return (v == '1) ? v : v + 1;
	endfunction

	function automatic void push_res(lbcd_pkg::kind_t k, logic [63:0] b, logic [63:0] s,
		logic [63:0] c);
		lbcd_pkg::res_t r;
		r = '0;
		r.kind = k;
		r.blk_num = b[TW-1:0];
		r.byte_start = s[AB-1:0];
		r.byte_count = c[lbcd_pkg::SIZE_W-1:0];
		expected_results.push_back(r);
	endfunction

	function automatic void predict_lookup(logic [63:0] off, logic [63:0] sz);
		int unsigned lg;
		logic [63:0] bsz, fin, sb, eb, bs, ps, pe, len;
		bit all_held;
		lg = (mdl_lg < 12) ? 12 : (mdl_lg > 24) ? 24 : mdl_lg;
		bsz = 64'd1 << lg;
		if (sz == 0) return;
		fin = off + sz - 1;
		if (fin > {24'd0, ADDR_TOP}) begin
			push_res(lbcd_pkg::K_SPAN, 0, 0, 0);
			return;
		end
		sb = off >> lg;
		eb = fin >> lg;
		if (eb > 64'hFFFFFFF || eb - sb + 1 > N_SPAN) begin
			push_res(lbcd_pkg::K_SPAN, 0, 0, 0);
			return;
		end
		all_held = 1;
		for (logic [63:0] b = sb; b <= eb; b++)
			if (find_block(b[TW-1:0]) < 0) all_held = 0;
		if (all_held) begin
			hits = sat_up(hits);
			for (logic [63:0] b = sb; b <= eb; b++) begin
				bs = b << lg;
				ps = (off > bs) ? off : bs;
				pe = off + sz;
				make_recent(find_block(b[TW-1:0]));
				if (bs + bsz < pe) pe = bs + bsz;
				if (mdl_file < pe) pe = mdl_file;
				push_res(lbcd_pkg::K_HIT, b, ps - bs, (pe > ps) ? pe - ps : 0);
			end
		end else begin
			for (logic [63:0] b = sb; b <= eb; b++)
				if (find_block(b[TW-1:0]) < 0) begin
					bs = b << lg;
					len = 0;
					if (bs < mdl_file) begin
						len = mdl_file - bs;
						if (len > bsz) len = bsz;
					end
					misses = sat_up(misses);
					push_res(lbcd_pkg::K_MISS, b, bs, len);
				end
		end
	endfunction

	function automatic void predict_fill(logic [TW-1:0] blk);
		int e, pick, slot;
		int unsigned cap;
		e = find_block(blk);
		if (e >= 0) make_recent(e);
		else begin
			cap = (mdl_cap < 1) ? 1 : (mdl_cap > N_ENT) ? N_ENT : mdl_cap;
			while (dir_occ >= cap && dir_occ > 0) begin
				pick = -1;
				for (int i = 0; i < N_ENT; i++)
					if (dir_vld[i] && (pick < 0 || dir_rank[i] > dir_rank[pick])) pick = i;
				dir_vld[pick] = 0;
				dir_occ--;
			end
			slot = -1;
			for (int i = 0; i < N_ENT; i++)
				if (dir_vld[i]) dir_rank[i]++;
				else if (slot < 0) slot = i;
			dir_tag[slot] = blk;
			dir_vld[slot] = 1;
			dir_rank[slot] = 0;
			dir_occ++;
		end
		push_res(lbcd_pkg::K_FILLED, blk, 0, 0);
	endfunction

	function automatic void predict_item(lbcd_pkg::req_t it);
		int base;
		base = expected_results.size();
		case (it.operation)
			lbcd_pkg::OP_LOOKUP: predict_lookup(it.offset, it.size);
			lbcd_pkg::OP_FILL:   predict_fill(it.block_index);
			lbcd_pkg::OP_CLEAR: begin
				for (int i = 0; i < N_ENT; i++) begin
					dir_vld[i] = 0;
					dir_rank[i] = 0;
				end
				dir_occ = 0;
				hits = 0;
				misses = 0;
				push_res(lbcd_pkg::K_CLEARED, 0, 0, 0);
			end
			default: ;
		endcase
		for (int k = base; k < expected_results.size(); k++) begin
			expected_results[k].hit_count = hits;
			expected_results[k].miss_count = misses;
			expected_results[k].last = (k == expected_results.size() - 1);
		end
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cmd <= '0;
			gap <= 0;
			reset_model();
		end else begin
			if (start && !busy) predict_item(cmd);
			if (start && busy) begin
				// hold the item
			end else if (gap > 0) begin
				gap <= gap - 1;
				start <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				gap <= $urandom_range(0, 14);
				start <= 1'b0;
			end else if (pending_items.size() > 0) begin
				cmd <= pending_items.pop_front();
				start <= 1'b1;
			end else
				start <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (expected_results.size() == 0) begin
				$display("%0t unexpected result: expected none got %p", $time, result);
				fail = 1;
			end else if (result !== expected_results[0]) begin
				$display("%0t mismatch: expected %p got %p", $time, expected_results[0], result);
				fail = 1;
				void'(expected_results.pop_front());
			end else
				void'(expected_results.pop_front());
		end
	end

	function automatic lbcd_pkg::req_t mk(lbcd_pkg::op_t op, logic [63:0] off, logic [63:0] sz,
		logic [63:0] b);
		lbcd_pkg::req_t r;
		r.operation = op;
		r.offset = off[AB-1:0];
		r.size = sz[lbcd_pkg::SIZE_W-1:0];
		r.block_index = b[TW-1:0];
		return r;
	endfunction

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	task automatic write_reg(lbcd_pkg::cfg_idx_t idx, logic [AB-1:0] v);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			lbcd_pkg::CFG_LG:  mdl_lg = v[lbcd_pkg::LG_W-1:0];
			lbcd_pkg::CFG_CAP: mdl_cap = v[lbcd_pkg::CAP_W-1:0];
			default:           mdl_file = v;
		endcase
	endtask

	task automatic drain();
		while (pending_items.size() > 0 || start || busy || expected_results.size() > 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	// mostly fills and lookups around a small block window so hits happen
	task automatic random_phase(int n, int unsigned lg);
		logic [63:0] base, b, off;
		int sel;
		base = $urandom_range(0, 40);
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(0, 99);
			b = base + $urandom_range(0, 12);
			off = (b << lg) + ($urandom & ((1 << lg) - 1));
			if (sel < 40)
				pending_items.push_back(mk(lbcd_pkg::OP_FILL, 0, 0, b));
			else if (sel < 80)
				pending_items.push_back(mk(lbcd_pkg::OP_LOOKUP, off,
					$urandom_range(1, 4 << lg), 0));
			else if (sel < 88)
				pending_items.push_back(mk(lbcd_pkg::OP_LOOKUP, rnd64(), rnd64(), 0));
			else if (sel < 93)
				pending_items.push_back(mk(lbcd_pkg::OP_FILL, rnd64(), rnd64(), rnd64()));
			else if (sel < 96)
				pending_items.push_back(mk(lbcd_pkg::OP_NOP, rnd64(), rnd64(), rnd64()));
			else
				pending_items.push_back(mk(lbcd_pkg::OP_CLEAR, rnd64(), rnd64(), rnd64()));
		end
	endtask

	initial begin
		quiet = 0;
		cfg_write = 1'b0;
		cfg_index = lbcd_pkg::CFG_LG;
		cfg_data = '0;
		mdl_lg = lbcd_pkg::LG_RESET;
		mdl_cap = lbcd_pkg::CAP_RESET;
		mdl_file = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset settings, file size zero
		pending_items.push_back(mk(lbcd_pkg::OP_LOOKUP, 0, 0, 0));
		pending_items.push_back(mk(lbcd_pkg::OP_LOOKUP, 0, 100, 0));
		pending_items.push_back(mk(lbcd_pkg::OP_FILL, 0, 0, 0));
		pending_items.push_back(mk(lbcd_pkg::OP_LOOKUP, 10, 100, 0));
		pending_items.push_back(mk(lbcd_pkg::OP_NOP, '1, '1, '1));
		drain();
		write_reg(lbcd_pkg::CFG_FILE, 40'h0000180000);
		write_reg(lbcd_pkg::CFG_LG, 40'd12);
		write_reg(lbcd_pkg::CFG_CAP, 40'd2);
		pending_items.push_back(mk(lbcd_pkg::OP_FILL, 0, 0, 1));
		pending_items.push_back(mk(lbcd_pkg::OP_FILL, 0, 0, 2));
		pending_items.push_back(mk(lbcd_pkg::OP_FILL, 0, 0, 1));
		pending_items.push_back(mk(lbcd_pkg::OP_FILL, 0, 0, 3));
		pending_items.push_back(mk(lbcd_pkg::OP_LOOKUP, 4096, 3 * 4096, 0));
		pending_items.push_back(mk(lbcd_pkg::OP_LOOKUP, 4096 + 7, 4096, 0));
		pending_items.push_back(mk(lbcd_pkg::OP_FILL, 0, 0, 28'hFFFFFFF));
		pending_items.push_back(mk(lbcd_pkg::OP_LOOKUP, ADDR_TOP, 2, 0));
		pending_items.push_back(mk(lbcd_pkg::OP_LOOKUP, ADDR_TOP, 1, 0));
		pending_items.push_back(mk(lbcd_pkg::OP_LOOKUP, 0, 17 * 4096, 0));
		pending_items.push_back(mk(lbcd_pkg::OP_LOOKUP, 0, 25'h1000000, 0));
		pending_items.push_back(mk(lbcd_pkg::OP_LOOKUP, 0, 16 * 4096, 0));
		pending_items.push_back(mk(lbcd_pkg::OP_CLEAR, 0, 0, 0));
		drain();
		write_reg(lbcd_pkg::CFG_LG, 40'd0);
		write_reg(lbcd_pkg::CFG_CAP, 40'd0);
		write_reg(lbcd_pkg::CFG_FILE, 40'd100);
		pending_items.push_back(mk(lbcd_pkg::OP_FILL, 0, 0, 0));
		pending_items.push_back(mk(lbcd_pkg::OP_FILL, 0, 0, 5));
		pending_items.push_back(mk(lbcd_pkg::OP_LOOKUP, 5 * 4096, 50, 0));
		drain();
		write_reg(lbcd_pkg::CFG_LG, 40'd31);
		write_reg(lbcd_pkg::CFG_CAP, 40'd127);
		write_reg(lbcd_pkg::CFG_FILE, ADDR_TOP);
		pending_items.push_back(mk(lbcd_pkg::OP_FILL, 0, 0, 0));
		pending_items.push_back(mk(lbcd_pkg::OP_LOOKUP, 0, 25'h1000000, 0));
		pending_items.push_back(mk(lbcd_pkg::OP_LOOKUP, 40'hFFFF000000, 25'h1000000, 0));
		drain();

		// random phases over several settings
		write_reg(lbcd_pkg::CFG_LG, 40'd12);
		write_reg(lbcd_pkg::CFG_CAP, 40'd6);
		write_reg(lbcd_pkg::CFG_FILE, 40'h0000030000);
		random_phase(50, 12);
		drain();
		write_reg(lbcd_pkg::CFG_LG, 40'($urandom_range(12, 24)));
		write_reg(lbcd_pkg::CFG_CAP, 40'($urandom_range(1, 64)));
		write_reg(lbcd_pkg::CFG_FILE, 40'(rnd64()));
		random_phase(50, mdl_lg);
		drain();
		write_reg(lbcd_pkg::CFG_LG, 40'd24);
		write_reg(lbcd_pkg::CFG_CAP, 40'd64);
		write_reg(lbcd_pkg::CFG_FILE, 40'h0004000000);
		quiet = 1;
		random_phase(50, 24);
		drain();

		if (!fail)
			$display("lru_block_cache_directory regression: pass");
		else
			$display("lru_block_cache_directory regression: fail");
		$finish;
	end
endmodule

// File: lru_block_cache_directory.f
hdl/lbcd_pkg.sv
hdl/lbcd_mem.sv
hdl/lbcd_ctrl.sv
hdl/lru_block_cache_directory.sv
tb/tb_lru_block_cache_directory.sv
